### hw/rtl/dense_graph_shortest_paths_unit_defines.svh
`ifndef DENSE_GRAPH_SHORTEST_PATHS_UNIT_DEFINES_SVH
`define DENSE_GRAPH_SHORTEST_PATHS_UNIT_DEFINES_SVH

// same-cycle implication
`define DGSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dgsp assertion failed");

// next-cycle implication
`define DGSP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dgsp assertion failed");

`endif

### hw/rtl/dgsp_pkg.sv
`default_nettype none
package dgsp_pkg;

    localparam int NUM_VERTICES = 8;
    localparam int WEIGHT_BITS  = 16;

    localparam int VID_W       = $clog2(NUM_VERTICES);
    localparam int CNT_W       = $clog2(NUM_VERTICES + 1);
    localparam int ADDR_W      = $clog2(NUM_VERTICES * NUM_VERTICES);
    localparam int COST_W      = WEIGHT_BITS + VID_W;
    localparam int OUT_COST_W  = 19;
    localparam int FIELD_VID_W = 3;
    localparam int IN_WEIGHT_W = 16;
    localparam int CMP_W       = (COST_W > OUT_COST_W) ? COST_W : OUT_COST_W;

    localparam logic [OUT_COST_W-1:0] COST_MAX = '1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_RELAX,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                   on;
        logic [WEIGHT_BITS-1:0] w;
    } t_edge;

    typedef struct packed {
        logic              load;
        logic              relax;
        logic              settle;
        logic [VID_W-1:0]  idx;
        logic [VID_W-1:0]  src;
        t_edge             ed;
        logic [COST_W-1:0] base;
    } t_bcast;

    typedef struct packed {
        logic              vld;
        logic [VID_W-1:0]  idx;
        logic [COST_W-1:0] cost;
    } t_link;

    typedef struct packed {
        logic              fin;
        logic              set;
        logic [COST_W-1:0] cost;
    } t_cell_st;

    function automatic logic [ADDR_W-1:0] edge_addr(input logic [VID_W-1:0] r,
                                                    input logic [VID_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(NUM_VERTICES) + ADDR_W'(c);
    endfunction

    function automatic logic [OUT_COST_W-1:0] sat_cost(input logic [COST_W-1:0] c);
        if (CMP_W'(c) > CMP_W'(COST_MAX)) begin
            return COST_MAX;
        end
        return OUT_COST_W'(c);
    endfunction

endpackage
`default_nettype wire

### hw/rtl/dgsp_edge_ram.sv
`default_nettype none
module dgsp_edge_ram import dgsp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire t_edge             i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output t_edge                  o_rdata
);

    localparam int DEPTH = NUM_VERTICES * NUM_VERTICES;

    t_edge             r_mem [DEPTH];
    logic  [DEPTH-1:0] r_vld;
    t_edge             r_rd;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    // entries never written read as no edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata.on = r_rd_vld & r_rd.on;
    assign o_rdata.w  = r_rd.w;

endmodule
`default_nettype wire

### hw/rtl/dgsp_cell.sv
`default_nettype none
module dgsp_cell import dgsp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [VID_W-1:0] i_idx,
    input  wire t_bcast           i_bc,
    input  wire t_link            i_link,
    output t_link                 o_link,
    output t_cell_st              o_st
);

    logic [COST_W-1:0] r_cost;
    logic              r_fin;
    logic              r_set;
    t_link             r_link;

    logic [COST_W-1:0] n_cost;
    logic              n_fin;
    logic              n_set;
    t_link             n_link;

    logic              w_hit;
    logic [COST_W-1:0] w_sum;
    logic              w_take;

    assign w_hit = (i_bc.idx == i_idx);
    assign w_sum = i_bc.base + COST_W'(i_bc.ed.w);

    // running minimum, earlier cell wins ties
    assign w_take = r_fin && !r_set && (!i_link.vld || (r_cost < i_link.cost));

    always_comb begin
        if (w_take) begin
            n_link.vld  = 1'b1;
            n_link.idx  = i_idx;
            n_link.cost = r_cost;
        end else begin
            n_link = i_link;
        end
    end

    always_comb begin
        n_cost = r_cost;
        n_fin  = r_fin;
        n_set  = r_set;
        if (i_bc.load && w_hit) begin
            if (i_bc.src == i_idx) begin
                n_cost = '0;
                n_fin  = 1'b1;
                n_set  = 1'b1;
            end else begin
                n_cost = i_bc.ed.on ? COST_W'(i_bc.ed.w) : '0;
                n_fin  = i_bc.ed.on;
                n_set  = 1'b0;
            end
        end else if (i_bc.relax && w_hit && !r_set && i_bc.ed.on) begin
            if (!r_fin || (w_sum < r_cost)) begin
                n_cost = w_sum;
                n_fin  = 1'b1;
            end
        end else if (i_bc.settle && w_hit) begin
            n_set = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin      <= 1'b0;
            r_set      <= 1'b0;
            r_link.vld <= 1'b0;
        end else begin
            r_fin  <= n_fin;
            r_set  <= n_set;
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cost <= n_cost;
    end

    assign o_link    = r_link;
    assign o_st.fin  = r_fin;
    assign o_st.set  = r_set;
    assign o_st.cost = r_cost;

endmodule
`default_nettype wire

### hw/rtl/dense_graph_shortest_paths_unit.sv
// Single-source shortest paths (Dijkstra) over a dense directed graph of NUM_VERTICES
// vertices. A load beat (cmd 0) writes one edge weight or clears one edge; loads are
// taken back to back while the unit is idle. A start beat (cmd 1) runs the search from
// the given source and is followed by one result beat per vertex in ascending order,
// with last on the final one. The search reads the source row from the edge memory
// through its one read port, then for each of at most N-1 rounds passes a running
// minimum along the chain of vertex cells and fetches the winner's row to relax it; it
// ends early once no reachable vertex is left. Input ready is high only while the unit
// is idle. The edge store reads as all "no edge" after reset with no clearing pass.
`default_nettype none
`include "dense_graph_shortest_paths_unit_defines.svh"
module dense_graph_shortest_paths_unit import dgsp_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_cmd,
    input  wire logic [FIELD_VID_W-1:0] i_row,
    input  wire logic [FIELD_VID_W-1:0] i_col,
    input  wire logic [IN_WEIGHT_W-1:0] i_weight,
    input  wire logic                   i_edge_present,
    input  wire logic [FIELD_VID_W-1:0] i_source,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [FIELD_VID_W-1:0]      o_vertex_id,
    output logic [OUT_COST_W-1:0]       o_path_cost,
    output logic                        o_reachable,
    output logic                        o_last
);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [VID_W-1:0]  r_round;
    logic [VID_W-1:0]  r_src;
    logic [VID_W-1:0]  r_u;
    logic [COST_W-1:0] r_cu;
    logic              r_pend_load;
    logic              r_pend_relax;
    logic [VID_W-1:0]  r_pidx;

    logic                   r_o_valid;
    logic [FIELD_VID_W-1:0] r_o_vid;
    logic [OUT_COST_W-1:0]  r_o_cost;
    logic                   r_o_reach;
    logic                   r_o_last;

    logic              w_in_acc;
    logic              w_start;
    logic              w_we;
    t_edge             w_wdata;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    t_edge             w_rdata;
    logic              w_rd_load;
    logic              w_rd_relax;
    logic              w_o_load;
    logic              w_decide;
    logic              w_settle;
    logic              w_cnt_end;
    logic              w_cnt_top;
    logic [VID_W-1:0]  w_idx;
    t_bcast            w_bc;
    t_link             w_end;

    t_link    w_link_in  [NUM_VERTICES];
    t_link    w_link_out [NUM_VERTICES];
    t_cell_st w_st       [NUM_VERTICES];

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_start  = w_in_acc && (i_cmd == CMD_START) && (32'(i_source) < NUM_VERTICES);
    assign w_we     = w_in_acc && (i_cmd == CMD_WRITE) && (32'(i_row) < NUM_VERTICES)
                      && (32'(i_col) < NUM_VERTICES);
    assign w_wdata.on = i_edge_present;
    assign w_wdata.w  = i_edge_present ? WEIGHT_BITS'(i_weight) : '0;
    assign w_waddr    = edge_addr(VID_W'(i_row), VID_W'(i_col));

    assign w_idx     = r_cnt[VID_W-1:0];
    assign w_cnt_end = (r_cnt == CNT_W'(NUM_VERTICES - 1));
    assign w_cnt_top = (r_cnt == CNT_W'(NUM_VERTICES));
    assign w_end     = w_link_out[NUM_VERTICES-1];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                if (w_cnt_end) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_cnt_top) begin
                    n_state = w_end.vld ? S_RELAX : S_OUT;
                end
            end
            S_RELAX: begin
                if (w_cnt_end) begin
                    n_state = (r_round == VID_W'(NUM_VERTICES - 2)) ? S_OUT : S_SCAN;
                end
            end
            S_OUT: begin
                if (w_o_load && w_cnt_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        w_rd_load  = (r_state == S_INIT);
        w_rd_relax = (r_state == S_RELAX);
        w_o_load   = (r_state == S_OUT) && (!r_o_valid || i_out_ready);
        w_decide   = (r_state == S_SCAN) && w_cnt_top;
        w_settle   = w_decide && w_end.vld;
        w_raddr    = w_rd_relax ? edge_addr(r_u, w_idx) : edge_addr(r_src, w_idx);
        if (n_state != r_state) begin
            n_cnt = '0;
        end else if ((r_state == S_OUT) ? w_o_load : (r_state != S_IDLE)) begin
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_comb begin
        w_bc.load   = r_pend_load;
        w_bc.relax  = r_pend_relax;
        w_bc.settle = w_settle;
        w_bc.idx    = w_settle ? w_end.idx : r_pidx;
        w_bc.src    = r_src;
        w_bc.ed     = w_rdata;
        w_bc.base   = r_cu;
    end

    dgsp_edge_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    for (genvar gi = 0; gi < NUM_VERTICES; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            assign w_link_in[gi] = '0;
        end else begin : g_body
            assign w_link_in[gi] = w_link_out[gi-1];
        end
        dgsp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (VID_W'(gi)),
            .i_bc    (w_bc),
            .i_link  (w_link_in[gi]),
            .o_link  (w_link_out[gi]),
            .o_st    (w_st[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_round      <= '0;
            r_pend_load  <= 1'b0;
            r_pend_relax <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_pend_load  <= w_rd_load;
            r_pend_relax <= w_rd_relax;
            if (w_start) begin
                r_round <= '0;
            end else if (w_rd_relax && w_cnt_end) begin
                r_round <= r_round + 1'b1;
            end
            if (w_o_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= w_idx;
        if (w_start) begin
            r_src <= VID_W'(i_source);
        end
        if (w_decide) begin
            r_u  <= w_end.idx;
            r_cu <= w_end.cost;
        end
        if (w_o_load) begin
            r_o_vid   <= FIELD_VID_W'(w_idx);
            r_o_cost  <= w_st[w_idx].fin ? sat_cost(w_st[w_idx].cost) : '0;
            r_o_reach <= w_st[w_idx].fin;
            r_o_last  <= w_cnt_end;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_vertex_id = r_o_vid;
    assign o_path_cost = r_o_cost;
    assign o_reachable = r_o_reach;
    assign o_last      = r_o_last;

    `DGSP_ASSERT_IMP(a_pick_unsettled, i_clk, i_rst_n, w_settle, w_st[w_end.idx].fin && !w_st[w_end.idx].set)
    `DGSP_ASSERT_IMP(a_src_settled, i_clk, i_rst_n, w_decide, w_st[r_src].set && w_st[r_src].fin)
    `DGSP_ASSERT_NXT(a_beat_from_out, i_clk, i_rst_n, !r_o_valid && (r_state != S_OUT), !r_o_valid)

endmodule
`default_nettype wire

### tb/sv/tb_dense_graph_shortest_paths_unit.sv
`default_nettype none
module tb_dense_graph_shortest_paths_unit;
    import dgsp_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int IDLE_PCT     = 27;
    localparam int RANDOM_ITEMS = 500;

    typedef struct packed {
        logic                   cmd;
        logic [FIELD_VID_W-1:0] row;
        logic [FIELD_VID_W-1:0] col;
        logic [IN_WEIGHT_W-1:0] weight;
        logic                   present;
        logic [FIELD_VID_W-1:0] source;
    } t_graph_cmd;

    typedef struct packed {
        logic [FIELD_VID_W-1:0] vid;
        logic [OUT_COST_W-1:0]  cost;
        logic                   reach;
        logic                   last;
    } t_path_result;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   i_out_ready    = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [FIELD_VID_W-1:0] o_vertex_id;
    logic [OUT_COST_W-1:0]  o_path_cost;
    logic                   o_reachable;
    logic                   o_last;
    t_graph_cmd             drv            = '0;

    t_graph_cmd   pending_cmds [$];
    t_path_result exp_paths [$];
    t_path_result want;

    logic                   edge_on [NUM_VERTICES][NUM_VERTICES];
    logic [WEIGHT_BITS-1:0] edge_w  [NUM_VERTICES][NUM_VERTICES];

    int  n_accepted = 0;
    int  n_errors   = 0;
    int  n_cycles   = 0;
    logic quiet;

    assign quiet = (n_accepted >= 150) && (n_accepted < 300);

    dense_graph_shortest_paths_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (drv.cmd),
        .i_row          (drv.row),
        .i_col          (drv.col),
        .i_weight       (drv.weight),
        .i_edge_present (drv.present),
        .i_source       (drv.source),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_vertex_id    (o_vertex_id),
        .o_path_cost    (o_path_cost),
        .o_reachable    (o_reachable),
        .o_last         (o_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void compute_shortest_paths(input logic [FIELD_VID_W-1:0] src);
        logic [23:0]  path_len [NUM_VERTICES];
        logic         fin      [NUM_VERTICES];
        logic         done     [NUM_VERTICES];
        logic [23:0]  c;
        int           pick;
        t_path_result r;
        for (int v = 0; v < NUM_VERTICES; v++) begin
            fin[v]      = edge_on[src][v];
            path_len[v] = edge_on[src][v] ? 24'(edge_w[src][v]) : 24'd0;
            done[v]     = 1'b0;
        end
        done[src]     = 1'b1;
        fin[src]      = 1'b1;
        path_len[src] = '0;
        for (int rnd = 0; rnd < NUM_VERTICES - 1; rnd++) begin
            pick = -1;
            for (int v = 0; v < NUM_VERTICES; v++) begin
                if (!done[v] && fin[v] && (pick < 0 || path_len[v] < path_len[pick])) begin
                    pick = v;
                end
            end
            if (pick < 0) begin
                break;
            end
            done[pick] = 1'b1;
            for (int w = 0; w < NUM_VERTICES; w++) begin
                if (!done[w] && edge_on[pick][w]) begin
                    c = path_len[pick] + 24'(edge_w[pick][w]);
                    if (!fin[w] || c < path_len[w]) begin
                        path_len[w] = c;
                        fin[w]      = 1'b1;
                    end
                end
            end
        end
        for (int v = 0; v < NUM_VERTICES; v++) begin
            r.vid   = FIELD_VID_W'(v);
            r.reach = fin[v];
            r.last  = (v == NUM_VERTICES - 1);
            if (!fin[v]) begin
                r.cost = '0;
            end else if (path_len[v] > 24'(COST_MAX)) begin
                r.cost = COST_MAX;
            end else begin
                r.cost = OUT_COST_W'(path_len[v]);
            end
            exp_paths.push_back(r);
        end
    endfunction

    function automatic void apply_graph_cmd(input t_graph_cmd c);
        if (c.cmd == CMD_WRITE) begin
            edge_on[c.row][c.col] = c.present;
            edge_w[c.row][c.col]  = c.present ? WEIGHT_BITS'(c.weight) : '0;
        end else begin
            compute_shortest_paths(c.source);
        end
    endfunction

    function automatic void log_bad(input string msg);
        if (n_errors < 10) begin
            $display("%s", msg);
        end
        n_errors++;
    endfunction

    function automatic t_graph_cmd random_fields();
        logic [$bits(t_graph_cmd)-1:0] raw;
        t_graph_cmd it;
        raw = $bits(t_graph_cmd)'($urandom);
        it  = raw;
        return it;
    endfunction

    function automatic void add_write(input int r, input int c, input int w, input logic p);
        t_graph_cmd it;
        it         = random_fields();
        it.cmd     = CMD_WRITE;
        it.row     = FIELD_VID_W'(r);
        it.col     = FIELD_VID_W'(c);
        it.weight  = IN_WEIGHT_W'(w);
        it.present = p;
        pending_cmds.push_back(it);
    endfunction

    function automatic void add_start(input int s);
        t_graph_cmd it;
        it        = random_fields();
        it.cmd    = CMD_START;
        it.source = FIELD_VID_W'(s);
        pending_cmds.push_back(it);
    endfunction

    function automatic int random_weight();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 3);
            1:       return $urandom_range(0, 255);
            2:       return $urandom_range(0, 65535);
            default: return ($urandom_range(0, 1) != 0) ? 65535 : 0;
        endcase
    endfunction

    initial begin
        for (int r = 0; r < NUM_VERTICES; r++) begin
            for (int c = 0; c < NUM_VERTICES; c++) begin
                edge_on[r][c] = 1'b0;
                edge_w[r][c]  = '0;
            end
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                apply_graph_cmd(drv);
                n_accepted <= n_accepted + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_cmds.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    drv        <= pending_cmds.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (exp_paths.size() == 0) begin
                    log_bad($sformatf("unexpected beat: vertex %0d cost %0d reach %0b last %0b",
                                      o_vertex_id, o_path_cost, o_reachable, o_last));
                end else begin
                    want = exp_paths.pop_front();
                    if (o_vertex_id !== want.vid || o_path_cost !== want.cost ||
                        o_reachable !== want.reach || o_last !== want.last) begin
                        log_bad($sformatf({"mismatch: expected vertex %0d cost %0d reach %0b ",
                                           "last %0b, got vertex %0d cost %0d reach %0b last %0b"},
                                          want.vid, want.cost, want.reach, want.last,
                                          o_vertex_id, o_path_cost, o_reachable, o_last));
                    end
                end
            end
            i_out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int nw;
        logic wipe;

        // empty graph
        add_start(0);
        // max-cost chain
        for (int v = 0; v < NUM_VERTICES - 1; v++) begin
            add_write(v, v + 1, 65535, 1'b1);
        end
        add_start(0);
        // self loop at source
        add_write(3, 3, 5, 1'b1);
        add_start(3);
        // zero weights and ties
        add_write(0, 7, 0, 1'b1);
        add_write(0, 2, 0, 1'b1);
        add_start(0);
        // edge removal
        add_write(0, 7, 65535, 1'b0);
        add_start(7);
        add_write(5, 1, 10, 1'b1);
        add_write(5, 2, 10, 1'b1);
        add_start(5);
        add_write(7, 0, 1, 1'b1);
        add_start(6);
        add_write(1, 2, 0, 1'b1);
        add_start(5);

        while (pending_cmds.size() < RANDOM_ITEMS + 25) begin
            nw   = $urandom_range(0, 10);
            wipe = ($urandom_range(0, 7) == 0);
            for (int k = 0; k < nw; k++) begin
                add_write($urandom_range(0, 7), $urandom_range(0, 7), random_weight(),
                          !wipe && ($urandom_range(0, 99) < 80));
            end
            add_start($urandom_range(0, 7));
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || i_in_valid || exp_paths.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && exp_paths.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
